FILE: hw/rtl/playf_pkg.sv
// Shared types, constants and square lookup functions for the Playfair digraph encryptor.
// No dependencies; every other RTL file takes names from here by scope.
`default_nettype none

package playf_pkg;

   localparam int SQ_DIM     = 5;
   localparam int CODE_W     = 5;
   localparam int ROW_W      = SQ_DIM * CODE_W;
   localparam int IDX_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   localparam logic [CODE_W-1:0] CODE_I = 5'd8;
   localparam logic [CODE_W-1:0] CODE_J = 5'd9;

   localparam logic [ROW_W-1:0]  ROW0_RST   = 25'd4294688;
   localparam logic [ROW_W-1:0]  ROW1_RST   = 25'd10755269;
   localparam logic [ROW_W-1:0]  ROW2_RST   = 25'd16201099;
   localparam logic [ROW_W-1:0]  ROW3_RST   = 25'd21613104;
   localparam logic [ROW_W-1:0]  ROW4_RST   = 25'd27024085;
   localparam logic [CODE_W-1:0] FILLER_RST = 5'd23;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0   = 3'd0,
      CSR_ROW1   = 3'd1,
      CSR_ROW2   = 3'd2,
      CSR_ROW3   = 3'd3,
      CSR_ROW4   = 3'd4,
      CSR_FILLER = 3'd5
   } csr_idx_type;

   typedef logic [SQ_DIM-1:0][ROW_W-1:0] square_type;

   typedef struct packed {
      logic [CODE_W-1:0] plain_letter;
      logic              end_of_message;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] cipher_first;
      logic [CODE_W-1:0] cipher_second;
      logic              final_pair;
   } rsp_type;

   // one plaintext digraph waiting for encryption
   typedef struct packed {
      logic [CODE_W-1:0] first;
      logic [CODE_W-1:0] second;
      logic              final_pair;
   } pair_job_type;

   // pairing stage output: up to two digraphs per letter
   typedef struct packed {
      logic         v0;
      logic         v1;
      pair_job_type job0;
      pair_job_type job1;
   } pair_stage_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } loc_type;

   // fold j onto i
   function automatic logic [CODE_W-1:0] fold_letter(logic [CODE_W-1:0] c);
      return (c == CODE_J) ? CODE_I : c;
   endfunction

   // step to next row or column, wrapping at the square edge
   function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] x);
      return (x == IDX_W'(SQ_DIM - 1)) ? '0 : x + IDX_W'(1);
   endfunction

   // find a letter; last match in row-major order wins, no match gives row 0 col 0
   function automatic loc_type locate(square_type sq, logic [CODE_W-1:0] letter);
      loc_type l;
      l = '0;
      for (int r = 0; r < SQ_DIM; r++) begin
         for (int c = 0; c < SQ_DIM; c++) begin
            if (sq[r][c*CODE_W +: CODE_W] == letter) begin
               l.row = IDX_W'(r);
               l.col = IDX_W'(c);
            end
         end
      end
      return l;
   endfunction

   // read one position of the square
   function automatic logic [CODE_W-1:0] cell_at(square_type sq, loc_type l);
      logic [CODE_W-1:0] code;
      logic [ROW_W-1:0]  row_bits;
      code     = '0;
      row_bits = '0;
      for (int r = 0; r < SQ_DIM; r++) begin
         if (l.row == IDX_W'(r)) begin
            row_bits = sq[r];
         end
      end
      for (int c = 0; c < SQ_DIM; c++) begin
         if (l.col == IDX_W'(c)) begin
            code = row_bits[c*CODE_W +: CODE_W];
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/playf_pair.sv
// Pairing stage: folds letters, tracks the pending letter, inserts filler and
// registers up to two plaintext digraphs per accepted beat. Depends on playf_pkg.
`default_nettype none

module playf_pair (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire playf_pkg::req_type            req_data,
   input  wire logic [playf_pkg::CODE_W-1:0]  filler,
   input  wire logic                          room,
   output playf_pkg::pair_stage_type          stage
);

   logic                         held_valid_ff, held_valid_in;
   logic [playf_pkg::CODE_W-1:0] held_letter_ff, held_letter_in;
   playf_pkg::pair_stage_type    stage_ff, stage_in;
   logic                         accept;
   logic                         advance;
   logic [playf_pkg::CODE_W-1:0] letter;
   logic [playf_pkg::CODE_W-1:0] fill;

   // stage drains into the result queue whenever the queue has room for two
   assign advance   = !stage_ff.v0 || room;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign letter    = playf_pkg::fold_letter(req_data.plain_letter);
   assign fill      = playf_pkg::fold_letter(filler);
   assign stage     = stage_ff;

   // build digraphs from the held letter and the new one
   always_comb begin
      held_valid_in  = held_valid_ff;
      held_letter_in = held_letter_ff;
      stage_in       = stage_ff;
      if (advance) begin
         stage_in.v0 = 1'b0;
         stage_in.v1 = 1'b0;
      end
      if (accept) begin
         stage_in.job0 = '{first: held_letter_ff, second: letter,
                           final_pair: req_data.end_of_message};
         stage_in.job1 = '{first: letter, second: fill, final_pair: 1'b1};
         if (!held_valid_ff) begin
            stage_in.job0 = '{first: letter, second: fill, final_pair: 1'b1};
            if (req_data.end_of_message) begin
               stage_in.v0 = 1'b1;
            end else begin
               held_letter_in = letter;
               held_valid_in  = 1'b1;
            end
         end else if (letter != held_letter_ff) begin
            stage_in.v0   = 1'b1;
            held_valid_in = 1'b0;
         end else begin
            // doubled letter: filler closes pair, letter held unless msg ends
            stage_in.job0 = '{first: held_letter_ff, second: fill, final_pair: 1'b0};
            stage_in.v0   = 1'b1;
            if (req_data.end_of_message) begin
               stage_in.v1   = 1'b1;
               held_valid_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         stage_ff.v0   <= 1'b0;
         stage_ff.v1   <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         stage_ff.v0   <= stage_in.v0;
         stage_ff.v1   <= stage_in.v1;
      end
      held_letter_ff <= held_letter_in;
      stage_ff.job0  <= stage_in.job0;
      stage_ff.job1  <= stage_in.job1;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/playf_encrypt.sv
// Digraph cipher unit: locates both letters in the key square and applies the
// row, column or rectangle rule. Combinational; depends on playf_pkg.
`default_nettype none

module playf_encrypt (
   input  wire playf_pkg::square_type   square,
   input  wire playf_pkg::pair_job_type job,
   output playf_pkg::rsp_type           result
);

   playf_pkg::loc_type loc_a, loc_b;
   playf_pkg::loc_type out_a, out_b;

   assign loc_a = playf_pkg::locate(square, job.first);
   assign loc_b = playf_pkg::locate(square, job.second);

   // pick the rule: same row shifts right, same column shifts down, else swap columns
   always_comb begin
      out_a = loc_a;
      out_b = loc_b;
      if (loc_a.row == loc_b.row) begin
         out_a.col = playf_pkg::wrap_inc(loc_a.col);
         out_b.col = playf_pkg::wrap_inc(loc_b.col);
      end else if (loc_a.col == loc_b.col) begin
         out_a.row = playf_pkg::wrap_inc(loc_a.row);
         out_b.row = playf_pkg::wrap_inc(loc_b.row);
      end else begin
         out_a.col = loc_b.col;
         out_b.col = loc_a.col;
      end
   end

   assign result.cipher_first  = playf_pkg::cell_at(square, out_a);
   assign result.cipher_second = playf_pkg::cell_at(square, out_b);
   assign result.final_pair    = job.final_pair;

endmodule

`default_nettype wire

FILE: hw/rtl/playf_rsp_fifo.sv
// Result queue: takes up to two digraphs a cycle and, while rsp_stall is low,
// hands out one beat a cycle. Depends on playf_pkg.
`default_nettype none

module playf_rsp_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire playf_pkg::push_type push,
   input  wire playf_pkg::rsp_type  data0,
   input  wire playf_pkg::rsp_type  data1,
   output logic                     room,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output playf_pkg::rsp_type       rsp_data
);

   playf_pkg::rsp_type              entry_ff [playf_pkg::FIFO_DEPTH];
   logic [playf_pkg::PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [playf_pkg::PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [playf_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [playf_pkg::PTR_W-1:0]     wr_next;
   logic                            pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= playf_pkg::CNT_W'(playf_pkg::FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + playf_pkg::PTR_W'(1);

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + playf_pkg::PTR_W'(push.first) + playf_pkg::PTR_W'(push.second);
      rd_ptr_in = rd_ptr_ff + playf_pkg::PTR_W'(pop);
      count_in  = count_ff + playf_pkg::CNT_W'(push.first) + playf_pkg::CNT_W'(push.second)
                  - playf_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store incoming digraphs
   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= data0;
      end
      if (push.second) begin
         entry_ff[wr_next] <= data1;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/playfair_digraph_encrypt.sv
// Playfair digraph encryptor top level: configuration registers, pairing stage,
// two cipher units and the result queue. Depends on playf_pkg and its submodules.
`default_nettype none

// Takes one plaintext letter per cycle while req_stall is low and emits encrypted
// digraphs. A letter accepted on one clock edge is paired and registered in the
// stage register, encrypted combinationally against the key square and written
// into a four-entry result queue when it has room, so its digraph reaches
// rsp_valid only after both the stage register and the queue.
// A doubled letter closing a message yields two digraphs from one letter; the
// queue takes both at once and the result port drains one beat a cycle, so a
// sustained rate of one letter per cycle holds as long as the consumer keeps up.
// req_stall rises only when the pairing register holds digraphs and the queue
// has fewer than two free entries. Key square rows and the filler letter are
// written through the csr_ port (always ready) and take effect on the next item;
// write them only while no message is in flight.
module playfair_digraph_encrypt (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire playf_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output playf_pkg::rsp_type                     rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [playf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [playf_pkg::ROW_W-1:0]       csr_wdata
);

   playf_pkg::square_type        square_ff;
   logic [playf_pkg::CODE_W-1:0] filler_ff;
   playf_pkg::pair_stage_type    stage;
   playf_pkg::push_type          push;
   playf_pkg::rsp_type           result0, result1;
   logic                         room;
   logic                         csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff[0] <= playf_pkg::ROW0_RST;
         square_ff[1] <= playf_pkg::ROW1_RST;
         square_ff[2] <= playf_pkg::ROW2_RST;
         square_ff[3] <= playf_pkg::ROW3_RST;
         square_ff[4] <= playf_pkg::ROW4_RST;
         filler_ff    <= playf_pkg::FILLER_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            playf_pkg::CSR_ROW0:   square_ff[0] <= csr_wdata;
            playf_pkg::CSR_ROW1:   square_ff[1] <= csr_wdata;
            playf_pkg::CSR_ROW2:   square_ff[2] <= csr_wdata;
            playf_pkg::CSR_ROW3:   square_ff[3] <= csr_wdata;
            playf_pkg::CSR_ROW4:   square_ff[4] <= csr_wdata;
            playf_pkg::CSR_FILLER: filler_ff    <= csr_wdata[playf_pkg::CODE_W-1:0];
            default: ;
         endcase
      end
   end

   playf_pair u_pair (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .filler    (filler_ff),
      .room      (room),
      .stage     (stage)
   );

   playf_encrypt u_enc0 (
      .square (square_ff),
      .job    (stage.job0),
      .result (result0)
   );

   playf_encrypt u_enc1 (
      .square (square_ff),
      .job    (stage.job1),
      .result (result1)
   );

   // hand the stage over when the queue can take it
   assign push.first  = stage.v0 && room;
   assign push.second = stage.v1 && room;

   playf_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data0     (result0),
      .data1     (result1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/playf_checker.sv
// Port-level checks for the Playfair digraph encryptor, bound to the top level.
// Depends on playf_pkg and playfair_digraph_encrypt.
`default_nettype none

module playf_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire playf_pkg::rsp_type              rsp_data
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input backpressure only when results are waiting
   a_stall_backed: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   // results appear only after a letter came in
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_beat) || $past(req_beat, 2))
      else $error("result without a recent input beat");

endmodule

bind playfair_digraph_encrypt playf_checker u_playf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
